### rtl/thm_pkg.sv
// Shared types and constants for the threshold hit merge block.
// No dependencies; every other file imports this package.
`default_nettype none

package thm_pkg;

  localparam int THM_TABLE_DEPTH = 256;
  localparam int THM_KEY_W       = 64;
  localparam int THM_ENERGY_W    = 32;
  localparam int THM_PS_W        = 32;
  localparam int THM_NOISE_W     = 32;
  localparam int THM_PROD_W      = 42;
  localparam int THM_TIME_W      = 43;
  localparam int THM_SLOT_W      = 8;
  localparam int THM_FS_PER_PS   = 1000;

  typedef struct packed {
    logic                    key_we;
    logic                    charge_we;
    logic [THM_KEY_W-1:0]    wkey;
    logic [THM_ENERGY_W-1:0] wcharge;
  } thm_wr_t;

endpackage

`default_nettype wire

### rtl/thm_if.sv
// Valid/ready channel interfaces for hit items and merged result items.
// Depends on thm_pkg for field widths.
`default_nettype none

interface thm_hit_if import thm_pkg::*;;
  logic                          valid;
  logic                          ready;
  logic                          event_start;
  logic [THM_KEY_W-1:0]          cell_key;
  logic [THM_ENERGY_W-1:0]       deposit_kev;
  logic [THM_PS_W-1:0]           particle_time_ps;
  logic signed [THM_NOISE_W-1:0] time_noise_fs;

  modport source (output valid, event_start, cell_key, deposit_kev, particle_time_ps,
                  time_noise_fs, input ready);
  modport sink (input valid, event_start, cell_key, deposit_kev, particle_time_ps,
                time_noise_fs, output ready);
endinterface

interface thm_res_if import thm_pkg::*;;
  logic                         valid;
  logic                         ready;
  logic [THM_SLOT_W-1:0]        slot_index;
  logic [THM_KEY_W-1:0]         cell_key_out;
  logic signed [THM_TIME_W-1:0] hit_time_fs;
  logic [THM_ENERGY_W-1:0]      total_charge;
  logic                         is_new;
  logic                         table_full;

  modport source (output valid, slot_index, cell_key_out, hit_time_fs, total_charge,
                  is_new, table_full, input ready);
  modport sink (input valid, slot_index, cell_key_out, hit_time_fs, total_charge,
                is_new, table_full, output ready);
endinterface

`default_nettype wire

### rtl/thm_table.sv
// Cell key and charge memories, one write port and one registered read port each.
// Depends on thm_pkg for the write request struct.
`default_nettype none

module thm_table import thm_pkg::*; #(
  parameter int TABLE_DEPTH = THM_TABLE_DEPTH,
  localparam int IW = $clog2(TABLE_DEPTH)
) (
  input  logic                    clk,
  input  thm_wr_t                 wr,
  input  logic [IW-1:0]           waddr,
  input  logic [IW-1:0]           raddr,
  output logic [THM_KEY_W-1:0]    key_rdata,
  output logic [THM_ENERGY_W-1:0] charge_rdata
);

  logic [THM_KEY_W-1:0]    key_mem    [TABLE_DEPTH];
  logic [THM_ENERGY_W-1:0] charge_mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.key_we) begin
      key_mem[waddr] <= wr.wkey;
    end
    if (wr.charge_we) begin
      charge_mem[waddr] <= wr.wcharge;
    end
    key_rdata    <= key_mem[raddr];
    charge_rdata <= charge_mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/thm_ctrl.sv
// Sequencer: threshold check, time computation, key scan with one shared comparator,
// charge update and result register. Depends on thm_pkg and thm_if.
`default_nettype none

module thm_ctrl import thm_pkg::*; #(
  parameter int TABLE_DEPTH = THM_TABLE_DEPTH,
  localparam int IW = $clog2(TABLE_DEPTH),
  localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [THM_ENERGY_W-1:0] threshold,
  thm_hit_if.sink                 hit,
  thm_res_if.source               res,
  output thm_wr_t                 wr,
  output logic [IW-1:0]           waddr,
  output logic [IW-1:0]           raddr,
  input  logic [THM_KEY_W-1:0]    key_rdata,
  input  logic [THM_ENERGY_W-1:0] charge_rdata
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_ADD  = 5'b00100,
    ST_SCAN = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  state_t                        state;
  logic [CW-1:0]                 count;
  logic [CW-1:0]                 idx;
  logic                          pend;
  logic [IW-1:0]                 pidx;
  logic [THM_KEY_W-1:0]          key;
  logic [THM_ENERGY_W-1:0]       dep;
  logic [THM_PS_W-1:0]           ps;
  logic signed [THM_NOISE_W-1:0] noise;
  logic [THM_PROD_W-1:0]         prod;
  logic signed [THM_TIME_W-1:0]  time_fs;
  logic [IW-1:0]                 res_slot;
  logic [THM_ENERGY_W-1:0]       res_charge;
  logic                          res_new;
  logic                          res_full;
  logic                          out_valid;
  logic [THM_SLOT_W-1:0]         out_slot;
  logic [THM_KEY_W-1:0]          out_key;
  logic signed [THM_TIME_W-1:0]  out_time;
  logic [THM_ENERGY_W-1:0]       out_charge;
  logic                          out_new;
  logic                          out_full;

  logic                          accept;
  logic                          match;
  logic                          more;
  logic                          room;
  logic                          out_free;
  logic [THM_ENERGY_W:0]         sum;
  logic [THM_ENERGY_W-1:0]       sat;

  assign hit.ready = (state == ST_IDLE);
  assign accept    = hit.valid && hit.ready;
  assign match     = (state == ST_SCAN) && pend && (key_rdata == key);
  assign more      = (idx < count);
  assign room      = (count != CW'(TABLE_DEPTH));
  assign out_free  = !out_valid || res.ready;
  assign sum       = {1'b0, charge_rdata} + {1'b0, dep};
  assign sat       = sum[THM_ENERGY_W] ? '1 : sum[THM_ENERGY_W-1:0];
  assign raddr     = idx[IW-1:0];

  always_comb begin
    wr.key_we    = (state == ST_SCAN) && !match && !more && room;
    wr.charge_we = wr.key_we || match;
    wr.wkey      = key;
    wr.wcharge   = match ? sat : dep;
    waddr        = match ? pidx : count[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      idx       <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && res.ready && (state != ST_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (hit.event_start) begin
              count <= '0;
            end
            if (!(hit.deposit_kev < threshold)) begin
              state <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          state <= ST_ADD;
        end
        ST_ADD: begin
          idx   <= '0;
          pend  <= 1'b0;
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (match) begin
            state <= ST_EMIT;
          end else if (more) begin
            pend <= 1'b1;
            idx  <= idx + CW'(1);
          end else begin
            if (room) begin
              count <= count + CW'(1);
            end
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key   <= hit.cell_key;
      dep   <= hit.deposit_kev;
      ps    <= hit.particle_time_ps;
      noise <= hit.time_noise_fs;
    end
    if (state == ST_MUL) begin
      prod <= THM_PROD_W'(ps) * THM_PROD_W'(THM_FS_PER_PS);
    end
    if (state == ST_ADD) begin
      time_fs <= $signed({1'b0, prod}) + THM_TIME_W'(noise);
    end
    if (state == ST_SCAN) begin
      pidx <= idx[IW-1:0];
      if (match) begin
        res_slot   <= pidx;
        res_charge <= sat;
        res_new    <= 1'b0;
        res_full   <= 1'b0;
      end else if (!more) begin
        res_slot   <= room ? count[IW-1:0] : '0;
        res_charge <= room ? dep : '0;
        res_new    <= room;
        res_full   <= !room;
      end
    end
    if ((state == ST_EMIT) && out_free) begin
      out_slot   <= THM_SLOT_W'(res_slot);
      out_key    <= key;
      out_time   <= time_fs;
      out_charge <= res_charge;
      out_new    <= res_new;
      out_full   <= res_full;
    end
  end

  assign res.valid        = out_valid;
  assign res.slot_index   = out_slot;
  assign res.cell_key_out = out_key;
  assign res.hit_time_fs  = out_time;
  assign res.total_charge = out_charge;
  assign res.is_new       = out_new;
  assign res.table_full   = out_full;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("fill count above table depth");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    (count > $past(count)) |-> (count == $past(count) + CW'(1)))
    else $error("fill count jumped");

  a_new_or_full: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_new && out_full))
    else $error("item marked both new and full");

  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_full) |-> (out_slot == '0 && out_charge == '0))
    else $error("full item carries slot or charge");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (idx <= count))
    else $error("scan index past fill count");

endmodule

`default_nettype wire

### rtl/threshold_hit_merge_by_cell.sv
// Threshold hit merge by cell: drops hits below the energy threshold and merges
// charge per cell key within an event. An accepted hit below threshold frees the
// input again on the next cycle. A kept hit passes through the multiply, add, scan
// and emit states before the input is ready again; the scan reads table entries until
// a match (at most the fill count, up to TABLE_DEPTH), one entry per cycle through
// the single read port of the key memory, and emit waits for the result register
// to drain. event_start empties the table by zeroing the fill count. Depends on
// thm_pkg, thm_if, thm_table and thm_ctrl.
`default_nettype none

module threshold_hit_merge_by_cell import thm_pkg::*; #(
  parameter int TABLE_DEPTH = THM_TABLE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [THM_ENERGY_W-1:0] cfg_wdata,
  thm_hit_if.sink                 hit,
  thm_res_if.source               res
);

  localparam int IW = $clog2(TABLE_DEPTH);

  logic [THM_ENERGY_W-1:0] energy_threshold;
  thm_wr_t                 wr;
  logic [IW-1:0]           waddr;
  logic [IW-1:0]           raddr;
  logic [THM_KEY_W-1:0]    key_rdata;
  logic [THM_ENERGY_W-1:0] charge_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      energy_threshold <= '0;
    end else if (cfg_we) begin
      energy_threshold <= cfg_wdata;
    end
  end

  thm_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk         (clk),
    .wr          (wr),
    .waddr       (waddr),
    .raddr       (raddr),
    .key_rdata   (key_rdata),
    .charge_rdata(charge_rdata)
  );

  thm_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .threshold   (energy_threshold),
    .hit         (hit),
    .res         (res),
    .wr          (wr),
    .waddr       (waddr),
    .raddr       (raddr),
    .key_rdata   (key_rdata),
    .charge_rdata(charge_rdata)
  );

endmodule

`default_nettype wire
